FILE: rtl/dvlg_pkg.sv
`default_nettype none
package dvlg_pkg;

  localparam int CoordW = 10;
  localparam logic [CoordW-1:0] COORD_MAX = 10'd1023;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // move code bits
  localparam int MV_X    = 3;
  localparam int MV_LEFT = 2;
  localparam int MV_Y    = 1;
  localparam int MV_DOWN = 0;

  typedef struct packed {
    logic active;
    logic xmajor;
    logic shallow;
    logic xneg;
    logic yneg;
  } mode_t;

  typedef struct packed {
    coord_t v;
    logic   hit;
  } clamp_t;

  // clamp a signed coordinate to the screen
  function automatic clamp_t clamp_coord(logic signed [15:0] v);
    clamp_t r;
    r.hit = 1'b0;
    r.v   = v[CoordW-1:0];
    if (v < 16'sd0) begin
      r.hit = 1'b1;
      r.v   = '0;
    end else if (v > $signed({6'b0, COORD_MAX})) begin
      r.hit = 1'b1;
      r.v   = COORD_MAX;
    end
    return r;
  endfunction

  // point arithmetic wraps at the coordinate width
  function automatic pt_t padd(pt_t a, pt_t b);
    pt_t r;
    r.x = a.x + b.x;
    r.y = a.y + b.y;
    return r;
  endfunction

  function automatic pt_t psub(pt_t a, pt_t b);
    pt_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dvlg_if.sv
`default_nettype none
interface dvlg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       intensify;
  logic       x_negative;
  logic [9:0] x_delta;
  logic       y_negative;
  logic [9:0] y_delta;
  logic [3:0] move_code;
  modport source (output valid, kind, intensify, x_negative, x_delta, y_negative, y_delta,
                  move_code, input ready);
  modport sink (input valid, kind, intensify, x_negative, x_delta, y_negative, y_delta,
                move_code, output ready);
endinterface

interface dvlg_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] pt0_x;
  logic [9:0] pt0_y;
  logic [9:0] pt1_x;
  logic [9:0] pt1_y;
  logic [9:0] pt2_x;
  logic [9:0] pt2_y;
  logic [9:0] pt3_x;
  logic [9:0] pt3_y;
  logic [3:0] point_valid;
  logic       line_done;
  logic       edge_hit;
  modport source (output valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
                  point_valid, line_done, edge_hit, input ready);
  modport sink (input valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
                point_valid, line_done, edge_hit, output ready);
endinterface

interface dvlg_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/display_vector_line_generator.sv
// result: the result word of an accepted word is registered on the edge that accepts it
// throughput: one word per cycle, a new word is taken while a result waits if the
//   result is taken in the same cycle (single output register)
// reset: pen at the origin, no line pending, scale_factor 1, output empty
`default_nettype none
module display_vector_line_generator
  import dvlg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dvlg_in_if.sink   vec_in,
  dvlg_out_if.source pt_out,
  dvlg_cfg_if.sink  cfg
);

  logic [3:0] scale;
  coord_t pen_x, pen_y;
  pt_t near_p, far_p;
  logic signed [15:0] decision, threshold_c, increment_one, increment_two;
  logic [7:0] steps_left;
  logic [1:0] leftover;
  mode_t line_mode;

  coord_t pen_x_next, pen_y_next;
  pt_t near_next, far_next;
  logic signed [15:0] decision_next, threshold_next, inc_one_next, inc_two_next;
  logic [7:0] steps_next;
  logic [1:0] leftover_next;
  mode_t mode_next;
  pt_t pts_next [4];
  logic [3:0] pv_next;
  logic edge_next;

  logic accept;
  assign vec_in.ready = !pt_out.valid || pt_out.ready;
  assign accept = vec_in.valid && vec_in.ready;
  assign cfg.ready = 1'b1;

  // per-item work
  always_comb begin
    logic [13:0] ax_s, ay_s;
    logic signed [15:0] xr, yr;
    clamp_t cx, cy;
    logic signed [10:0] ddx, ddy;
    coord_t adx, ady, len, mnr, lenm1;
    logic signed [15:0] inc2, thr, inc1;
    logic shallow;
    pt_t maj, mnv, n0, f0, u, v;
    logic cond1, condc;
    logic b1, b2, b3;
    ax_s = '0; ay_s = '0; xr = '0; yr = '0; cx = '0; cy = '0;
    ddx = '0; ddy = '0; adx = '0; ady = '0; len = '0; mnr = '0; lenm1 = '0;
    inc2 = '0; thr = '0; inc1 = '0; shallow = 1'b0;
    b1 = 1'b0; b2 = 1'b0; b3 = 1'b0;
    u = '0; v = '0;
    pen_x_next = pen_x; pen_y_next = pen_y;
    near_next = near_p; far_next = far_p;
    decision_next = decision; threshold_next = threshold_c;
    inc_one_next = increment_one; inc_two_next = increment_two;
    steps_next = steps_left; leftover_next = leftover; mode_next = line_mode;
    for (int k = 0; k < 4; k++) pts_next[k] = '0;
    pv_next = '0;
    edge_next = 1'b0;

    // step vectors of the pending line
    maj = '0; mnv = '0;
    if (line_mode.xmajor) begin
      maj.x = line_mode.xneg ? '1 : coord_t'(1);
      mnv.y = line_mode.yneg ? '1 : coord_t'(1);
    end else begin
      maj.y = line_mode.yneg ? '1 : coord_t'(1);
      mnv.x = line_mode.xneg ? '1 : coord_t'(1);
    end
    n0 = padd(near_p, maj);
    f0 = psub(far_p, maj);
    cond1 = line_mode.shallow ? (decision < 16'sd0) : (decision > 16'sd0);
    condc = decision < threshold_c;

    case (vec_in.kind)
      KIND_LOAD: begin
        ax_s = {4'b0, vec_in.x_delta} * {10'b0, scale};
        ay_s = {4'b0, vec_in.y_delta} * {10'b0, scale};
        xr = vec_in.x_negative ? $signed({6'b0, pen_x}) - $signed({2'b0, ax_s})
                               : $signed({6'b0, pen_x}) + $signed({2'b0, ax_s});
        yr = vec_in.y_negative ? $signed({6'b0, pen_y}) - $signed({2'b0, ay_s})
                               : $signed({6'b0, pen_y}) + $signed({2'b0, ay_s});
        cx = clamp_coord(xr);
        cy = clamp_coord(yr);
        edge_next = cx.hit || cy.hit;
        pen_x_next = cx.v;
        pen_y_next = cy.v;
        mode_next = '0;
        steps_next = '0;
        leftover_next = '0;
        if (vec_in.intensify) begin
          ddx = $signed({1'b0, cx.v}) - $signed({1'b0, pen_x});
          ddy = $signed({1'b0, cy.v}) - $signed({1'b0, pen_y});
          adx = ddx[10] ? coord_t'(-ddx) : ddx[9:0];
          ady = ddy[10] ? coord_t'(-ddy) : ddy[9:0];
          pts_next[0] = '{x: pen_x, y: pen_y};
          pv_next = 4'b0001;
          if (adx != '0 || ady != '0) begin
            pts_next[1] = '{x: cx.v, y: cy.v};
            pv_next = 4'b0011;
            if (adx > ady) begin
              len = adx; mnr = ady;
            end else begin
              len = ady; mnr = adx;
            end
            inc2 = $signed({4'b0, mnr, 2'b0}) - $signed({5'b0, len, 1'b0});
            shallow = inc2 < 16'sd0;
            thr = shallow ? $signed({5'b0, mnr, 1'b0})
                          : $signed({5'b0, mnr, 1'b0}) - $signed({5'b0, len, 1'b0});
            inc1 = thr <<< 1;
            decision_next = shallow ? inc1 - $signed({6'b0, len})
                                    : inc1 + $signed({6'b0, len});
            threshold_next = thr;
            inc_one_next = inc1;
            inc_two_next = inc2;
            lenm1 = len - coord_t'(1);
            steps_next = lenm1[9:2];
            leftover_next = lenm1[1:0];
            near_next = '{x: pen_x, y: pen_y};
            far_next = '{x: cx.v, y: cy.v};
            mode_next.active = lenm1 != '0;
            mode_next.xmajor = adx > ady;
            mode_next.shallow = shallow;
            mode_next.xneg = ddx[10];
            mode_next.yneg = ddy[10];
          end
        end
      end
      KIND_TICK: begin
        if (line_mode.active) begin
          if (steps_left != '0) begin
            // one two-step iteration from both ends
            if (cond1) begin
              u = line_mode.shallow ? pt_t'('0) : mnv;
              v = line_mode.shallow ? maj : padd(maj, mnv);
              decision_next = decision + increment_one;
            end else begin
              u = condc ? pt_t'('0) : mnv;
              v = condc ? padd(maj, mnv) : maj;
              decision_next = decision + increment_two;
            end
            pts_next[0] = padd(n0, u);
            pts_next[1] = padd(pts_next[0], v);
            pts_next[2] = psub(f0, u);
            pts_next[3] = psub(pts_next[2], v);
            near_next = pts_next[1];
            far_next = pts_next[3];
            pv_next = 4'b1111;
            steps_next = steps_left - 8'd1;
            if (steps_left == 8'd1 && leftover == '0) mode_next = '0;
          end else begin
            // tail group of one to three points
            if (cond1) begin
              b1 = !line_mode.shallow; b2 = b1; b3 = b1;
            end else if (condc) begin
              b1 = 1'b0; b2 = 1'b1; b3 = 1'b0;
            end else begin
              b1 = 1'b1; b2 = 1'b0;
              b3 = line_mode.shallow || (decision > threshold_c);
            end
            pts_next[0] = b1 ? padd(n0, mnv) : n0;
            pts_next[1] = b2 ? padd(padd(pts_next[0], maj), mnv) : padd(pts_next[0], maj);
            pts_next[2] = b3 ? psub(f0, mnv) : f0;
            case (leftover)
              2'd1: pv_next = 4'b0001;
              2'd2: pv_next = 4'b0011;
              2'd3: pv_next = 4'b0111;
              default: pv_next = 4'b0000;
            endcase
            if (!pv_next[1]) pts_next[1] = '0;
            if (!pv_next[2]) pts_next[2] = '0;
            if (!pv_next[0]) pts_next[0] = '0;
            leftover_next = '0;
            mode_next = '0;
          end
        end
      end
      KIND_MOVE: begin
        mode_next = '0;
        steps_next = '0;
        leftover_next = '0;
        if (vec_in.move_code[MV_X]) begin
          xr = vec_in.move_code[MV_LEFT] ? $signed({6'b0, pen_x}) - $signed({12'b0, scale})
                                         : $signed({6'b0, pen_x}) + $signed({12'b0, scale});
          cx = clamp_coord(xr);
          pen_x_next = cx.v;
        end
        if (!cx.hit && vec_in.move_code[MV_Y]) begin
          yr = vec_in.move_code[MV_DOWN] ? $signed({6'b0, pen_y}) - $signed({12'b0, scale})
                                         : $signed({6'b0, pen_y}) + $signed({12'b0, scale});
          cy = clamp_coord(yr);
          pen_y_next = cy.v;
        end
        edge_next = cx.hit || cy.hit;
        if (!edge_next && vec_in.intensify) begin
          pts_next[0] = '{x: pen_x_next, y: pen_y_next};
          pv_next = 4'b0001;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= 4'd1;
      pen_x <= '0;
      pen_y <= '0;
      near_p <= '0;
      far_p <= '0;
      decision <= '0;
      threshold_c <= '0;
      increment_one <= '0;
      increment_two <= '0;
      steps_left <= '0;
      leftover <= '0;
      line_mode <= '0;
    end else begin
      if (cfg.valid) scale <= cfg.data;
      if (accept) begin
        pen_x <= pen_x_next;
        pen_y <= pen_y_next;
        near_p <= near_next;
        far_p <= far_next;
        decision <= decision_next;
        threshold_c <= threshold_next;
        increment_one <= inc_one_next;
        increment_two <= inc_two_next;
        steps_left <= steps_next;
        leftover <= leftover_next;
        line_mode <= mode_next;
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else if (accept) begin
      pt_out.valid <= 1'b1;
    end else if (pt_out.ready) begin
      pt_out.valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pt_out.pt0_x <= pts_next[0].x;
      pt_out.pt0_y <= pts_next[0].y;
      pt_out.pt1_x <= pts_next[1].x;
      pt_out.pt1_y <= pts_next[1].y;
      pt_out.pt2_x <= pts_next[2].x;
      pt_out.pt2_y <= pts_next[2].y;
      pt_out.pt3_x <= pts_next[3].x;
      pt_out.pt3_y <= pts_next[3].y;
      pt_out.point_valid <= pv_next;
      pt_out.line_done <= !mode_next.active;
      pt_out.edge_hit <= edge_next;
    end
  end

endmodule
`default_nettype wire
